/* hw/rtl/kfd_pkg.sv */
// Shared types and constants for the keypad frame deframer and decoder.
`default_nettype none
package kfd_pkg;

    // Message kinds carried in msg_kind
    typedef enum logic [1:0] {
        KIND_TEACHER = 2'd0,
        KIND_STUDENT = 2'd1,
        KIND_SETID   = 2'd2
    } t_kind;

    // Frame class codes taken from bits 6..5 of the first byte
    localparam logic [1:0] CLS_KEY    = 2'd0;
    localparam logic [1:0] CLS_ANSWER = 2'd1;
    localparam logic [1:0] CLS_SETID  = 2'd2;

    // Sub-codes of the key class (bits 4..0 of the first byte)
    localparam logic [4:0] KEY_TEACHER = 5'd0;
    localparam logic [4:0] KEY_RUSH    = 5'd1;
    localparam logic [4:0] KEY_ANS_LO  = 5'd2;
    localparam logic [4:0] KEY_ANS_HI  = 5'd5;

    // Set-id frames need a zero sub-code in byte 1
    localparam logic [2:0] SETID_SUB   = 3'd0;

    // Answer codes: letters 0..5, rush 6
    localparam logic [2:0] ANSWER_NONE = 3'd0;
    localparam logic [2:0] ANSWER_LAST = 3'd5;
    localparam logic [2:0] ANSWER_RUSH = 3'd6;

    // Three-byte frame, first received byte first
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_frame;

    // Found-frame word handed from the window stage to the decoder
    typedef struct packed {
        logic   valid;
        t_frame frame;
    } t_frm_word;

endpackage
`default_nettype wire

/* hw/rtl/kfd_if.sv */
// Handshake interfaces: received byte stream and decoded message stream.
`default_nettype none
interface kfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface kfd_msg_if;
    logic          valid;
    logic          ready;
    kfd_pkg::t_kind msg_kind;
    logic [8:0]    keypad_id;
    logic [2:0]    answer_code;
    logic [3:0]    teacher_key;
    logic [23:0]   raw_frame;

    modport source (output valid, output msg_kind, output keypad_id, output answer_code,
                    output teacher_key, output raw_frame, input ready);
    modport sink   (input valid, input msg_kind, input keypad_id, input answer_code,
                    input teacher_key, input raw_frame, output ready);
endinterface
`default_nettype wire

/* hw/rtl/kfd_window.sv */
// Sliding three-byte window: frame check and registered found-frame word.
`default_nettype none
module kfd_window (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_acc,
    input  wire logic [7:0]         i_byte,
    input  wire logic               i_en,
    output kfd_pkg::t_frm_word      o_frm
);
    import kfd_pkg::*;

    logic [7:0] r_b0, n_b0;
    logic [7:0] r_b1, n_b1;
    logic [1:0] r_fill, n_fill;
    logic       r_fvalid, n_fvalid;
    t_frame     r_frame;
    logic       full;
    logic       match;

    // Frame check on the held pair plus the incoming byte
    assign full  = (r_fill == 2'd2);
    assign match = full && !r_b0[7] && (i_byte == (r_b0 ^ r_b1));

    // Window update for an accepted word
    always_comb begin
        n_b0   = r_b0;
        n_b1   = r_b1;
        n_fill = r_fill;
        if (i_acc) begin
            if (!full) begin
                if (r_fill[0]) begin
                    n_b1 = i_byte;
                end else begin
                    n_b0 = i_byte;
                end
                n_fill = r_fill + 2'd1;
            end else if (match) begin
                n_b0   = '0;
                n_b1   = '0;
                n_fill = '0;
            end else begin
                n_b0 = r_b1;
                n_b1 = i_byte;
            end
        end
    end

    assign n_fvalid = i_acc && match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0   <= '0;
            r_b1   <= '0;
            r_fill <= '0;
        end else begin
            r_b0   <= n_b0;
            r_b1   <= n_b1;
            r_fill <= n_fill;
        end
    end

    // Found-frame register, advances with the output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvalid <= 1'b0;
        end else if (i_en) begin
            r_fvalid <= n_fvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_frame <= '{b0: r_b0, b1: r_b1, b2: i_byte};
        end
    end

    assign o_frm = '{valid: r_fvalid, frame: r_frame};

    // Fill count never goes past two held bytes
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != 2'd3) else $error("window fill out of range");

    // A found frame always empties the window
    a_frame_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && match) |=> (r_fill == 2'd0)) else $error("window not emptied");

    // A word taken into a part-filled window never yields a frame
    a_fill_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_acc && !full) |=> !r_fvalid) else $error("frame from partial window");

endmodule
`default_nettype wire

/* hw/rtl/kfd_decode.sv */
// Frame decoder with the result register that drives the message channel.
`default_nettype none
module kfd_decode (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire kfd_pkg::t_frm_word i_frm,
    output logic                    o_en,
    kfd_msg_if.source               o_msg
);
    import kfd_pkg::*;

    logic        r_valid;
    t_kind       r_kind, n_kind;
    logic [8:0]  r_id, n_id;
    logic [2:0]  r_ans, n_ans;
    logic [3:0]  r_tkey, n_tkey;
    logic [23:0] r_raw;
    logic        n_known;
    logic [1:0]  c1;
    logic [4:0]  k1;
    logic [2:0]  c2;
    logic [3:0]  k2;

    assign c1 = i_frm.frame.b0[6:5];
    assign k1 = i_frm.frame.b0[4:0];
    assign c2 = i_frm.frame.b1[6:4];
    assign k2 = i_frm.frame.b1[3:0];

    // The pipeline moves whenever the result register is free or being taken
    assign o_en = !r_valid || o_msg.ready;

    // Code decode
    always_comb begin
        n_known = 1'b0;
        n_kind  = KIND_STUDENT;
        n_id    = {5'd0, k2};
        n_ans   = ANSWER_NONE;
        n_tkey  = 4'd0;
        case (c1)
            CLS_KEY: begin
                if (k1 == KEY_TEACHER) begin
                    n_known = 1'b1;
                    n_kind  = KIND_TEACHER;
                    n_id    = '0;
                    n_tkey  = k2;
                end else if (k1 == KEY_RUSH) begin
                    n_known = 1'b1;
                    n_ans   = ANSWER_RUSH;
                end else if (k1 inside {[KEY_ANS_LO:KEY_ANS_HI]}) begin
                    n_known = 1'b1;
                    n_ans   = 3'(k1 - KEY_ANS_LO);
                end
            end
            CLS_ANSWER: begin
                n_known = 1'b1;
                n_ans   = (c2 <= ANSWER_LAST) ? c2 : ANSWER_RUSH;
            end
            CLS_SETID: begin
                if (c2 == SETID_SUB) begin
                    n_known = 1'b1;
                    n_kind  = KIND_SETID;
                    n_id    = {k1, k2};
                end
            end
            default: begin
                n_known = 1'b0;
            end
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_frm.valid && n_known;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_kind <= n_kind;
            r_id   <= n_id;
            r_ans  <= n_ans;
            r_tkey <= n_tkey;
            r_raw  <= i_frm.frame;
        end
    end

    assign o_msg.valid       = r_valid;
    assign o_msg.msg_kind    = r_kind;
    assign o_msg.keypad_id   = r_id;
    assign o_msg.answer_code = r_ans;
    assign o_msg.teacher_key = r_tkey;
    assign o_msg.raw_frame   = r_raw;

    // A delivered message always carries a well-formed frame
    a_raw_checks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (!r_raw[23] && (r_raw[7:0] == (r_raw[23:16] ^ r_raw[15:8]))))
        else $error("message from bad frame");

    // Teacher messages carry keypad zero and no answer
    a_teacher_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind == KIND_TEACHER) |-> (r_id == 9'd0 && r_ans == ANSWER_NONE))
        else $error("teacher message fields");

    // Student ids fit a nibble and answers stop at rush
    a_student_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind == KIND_STUDENT) |->
        (r_id[8:4] == 5'd0 && r_ans <= ANSWER_RUSH && r_tkey == 4'd0))
        else $error("student message fields");

endmodule
`default_nettype wire

/* hw/rtl/keypad_frame_deframer_decoder_top.sv */
// Top level of the keypad frame deframer and decoder.
//
// Takes one received byte per cycle on i_rx and slides a three-byte window
// over the stream; a window whose first byte has bit 7 clear and whose third
// byte is the XOR of the first two is a frame and is consumed whole, otherwise
// the oldest byte drops out. Frames with a known code come out on o_msg as one
// message (teacher key, student answer or set keypad id) with the raw frame;
// frames with an unknown code are consumed silently. One byte is taken per
// cycle while i_rx.ready is high; a message follows the byte closing its frame
// (found-frame register, then result register). i_rx.ready follows o_msg: it
// is low only while a message waits in the result register and is not taken.
`default_nettype none
module keypad_frame_deframer_decoder_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    kfd_byte_if.sink    i_rx,
    kfd_msg_if.source   o_msg
);
    import kfd_pkg::*;

    logic      en;
    logic      acc;
    t_frm_word frm;

    assign i_rx.ready = en;
    assign acc        = i_rx.valid && en;

    kfd_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_byte  (i_rx.rx_byte),
        .i_en    (en),
        .o_frm   (frm)
    );

    kfd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frm   (frm),
        .o_en    (en),
        .o_msg   (o_msg)
    );

endmodule
`default_nettype wire
